[sv/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// Fit partition allocator package
// Shared field widths, codes, defaults and control types for the allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // Default sizes of the partition table.
    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    // Widths of the transfer payload fields.
    localparam int OPCODE_W   = 1;
    localparam int SLOT_W     = 4;
    localparam int SIZE_W     = 16;
    localparam int REQ_NUM_W  = 16;
    localparam int CHOSEN_W   = 4;
    localparam int ORIG_W     = 16;

    // Configuration register widths and port shape.
    localparam int POLICY_W   = 2;
    localparam int PIU_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 1'd1;

    // Configuration reset values.
    localparam logic [POLICY_W-1:0] POLICY_RESET = 2'd0;
    localparam logic [PIU_W-1:0]    PIU_RESET    = 5'd16;

    // Fit policy codes. The unused code behaves as first fit.
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // Item opcodes.
    localparam logic [OPCODE_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_REQUEST = 1'b1;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;   // Start of a new request scan.
        logic valid;   // Read data for the current index is present.
    } t_cmp_ctrl;

endpackage

[sv/fpa_req_if.sv]
// ----------------------------------------------------------------------------
// Allocator input channel
// Valid/ready channel that carries load and request items.
// ----------------------------------------------------------------------------
interface fpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [fpa_pkg::OPCODE_W-1:0]  opcode;
    logic [fpa_pkg::SLOT_W-1:0]    partition_slot;
    logic [fpa_pkg::SIZE_W-1:0]    size_value;

    modport source (
        output valid, opcode, partition_slot, size_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, partition_slot, size_value,
        output ready
    );
endinterface

[sv/fpa_rsp_if.sv]
// ----------------------------------------------------------------------------
// Allocator result channel
// Valid/ready channel that carries one result per allocation request.
// ----------------------------------------------------------------------------
interface fpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fpa_pkg::REQ_NUM_W-1:0] request_number;
    logic                          granted;
    logic [fpa_pkg::CHOSEN_W-1:0]  chosen_partition;
    logic [fpa_pkg::ORIG_W-1:0]    original_size;

    modport source (
        output valid, request_number, granted, chosen_partition, original_size,
        input  ready
    );

    modport sink (
        input  valid, request_number, granted, chosen_partition, original_size,
        output ready
    );
endinterface

[sv/fpa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/fpa_fit_cmp.sv]
// ----------------------------------------------------------------------------
// Fit compare unit
// Checks one partition per cycle against the request and keeps the pick.
// ----------------------------------------------------------------------------
module fpa_fit_cmp #(
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fpa_pkg::t_cmp_ctrl               i_ctrl,
    input  logic [fpa_pkg::POLICY_W-1:0]     i_policy,
    input  logic [SIZE_BITS-1:0]             i_size,
    input  logic [IDX_W-1:0]                 i_idx,
    input  logic [SIZE_BITS-1:0]             i_data,
    output logic                             o_found,
    output logic [IDX_W-1:0]                 o_pick,
    output logic [SIZE_BITS-1:0]             o_best
);

    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic                 fits;
    logic                 below_best;
    logic                 take;

    // The two comparators: against the request and against the current pick.
    assign fits       = (i_data >= i_size);
    assign below_best = (i_data < r_best);

    // Policy decides whether this entry replaces the current pick.
    always_comb begin
        case (i_policy)
            fpa_pkg::POLICY_BEST:  take = fits && (!r_found || below_best);
            fpa_pkg::POLICY_WORST: take = fits && (!r_found || !below_best);
            default:               take = fits && !r_found;
        endcase
    end

    // Pick registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctrl.valid && take) begin
            r_found <= 1'b1;
        end
        if (i_ctrl.valid && take) begin
            r_pick <= i_idx;
            r_best <= i_data;
        end
    end

    assign o_found = r_found;
    assign o_pick  = r_pick;
    assign o_best  = r_best;

endmodule

[sv/fit_partition_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Fit partition allocator
// Fixed partition table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Sequence: a request scans partitions_in_use entries (capped at MAX_PARTITIONS) in
// S_SCAN, writes the reduced size back on a grant in S_UPDATE, and registers its result.
// Ready is high only in S_IDLE, so the next item is taken only after the previous request
// has reached S_FINISH; a load keeps the sequencer in S_IDLE and ready stays high after it.
// A result cycle stalls while the output register still holds an untaken result.
// Synchronous active-low reset clears control, config and the request counter only.
module fit_partition_allocator_unit #(
    parameter int MAX_PARTITIONS = fpa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fpa_pkg::SIZE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    fpa_req_if.sink                          i_req,
    fpa_rsp_if.source                        o_rsp
);

    localparam int IDX_W   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_PARTITIONS + 1);
    localparam int LIM_W   = (CNT_W > fpa_pkg::PIU_W) ? CNT_W : fpa_pkg::PIU_W;
    localparam int SLOTC_W = (CNT_W > fpa_pkg::SLOT_W) ? CNT_W : fpa_pkg::SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FINISH
    } t_state;

    // Configuration registers.
    logic [fpa_pkg::POLICY_W-1:0] r_policy;
    logic [fpa_pkg::PIU_W-1:0]    r_piu;

    // Sequencer state and registered outputs.
    t_state                        r_state, n_state;
    logic [LIM_W-1:0]              r_idx, n_idx;
    logic [LIM_W-1:0]              r_limit, n_limit;
    logic                          r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]              r_cmp_idx, n_cmp_idx;
    logic [SIZE_BITS-1:0]          r_size, n_size;
    logic [fpa_pkg::REQ_NUM_W-1:0] r_req_cnt, n_req_cnt;
    logic                          r_out_valid, n_out_valid;
    logic [fpa_pkg::REQ_NUM_W-1:0] r_out_num, n_out_num;
    logic                          r_out_granted, n_out_granted;
    logic [fpa_pkg::CHOSEN_W-1:0]  r_out_chosen, n_out_chosen;
    logic [fpa_pkg::ORIG_W-1:0]    r_out_orig, n_out_orig;

    logic                          req_xfer;
    logic                          rsp_xfer;
    logic                          is_load;
    logic                          is_request;
    logic                          slot_ok;
    logic [LIM_W-1:0]              piu_ext;
    logic [LIM_W-1:0]              max_ext;
    logic [LIM_W-1:0]              scan_limit;
    logic [SIZE_BITS-1:0]          in_size;

    fpa_pkg::t_cmp_ctrl            cmp_ctrl;
    logic                          cmp_found;
    logic [IDX_W-1:0]              cmp_pick;
    logic [SIZE_BITS-1:0]          cmp_best;

    logic                          rem_we;
    logic [IDX_W-1:0]              rem_waddr;
    logic [SIZE_BITS-1:0]          rem_wdata;
    logic [SIZE_BITS-1:0]          rem_rdata;
    logic                          lds_we;
    logic [SIZE_BITS-1:0]          lds_rdata;

    // Handshake decode.
    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;
    assign rsp_xfer    = o_rsp.valid && o_rsp.ready;
    assign is_load     = req_xfer && (i_req.opcode == fpa_pkg::OP_LOAD);
    assign is_request  = req_xfer && (i_req.opcode == fpa_pkg::OP_REQUEST);
    assign in_size     = SIZE_BITS'(i_req.size_value);
    assign slot_ok     = SLOTC_W'(i_req.partition_slot) < SLOTC_W'(MAX_PARTITIONS);

    // Number of partitions scanned, capped at the table depth.
    assign piu_ext    = LIM_W'(r_piu);
    assign max_ext    = LIM_W'(MAX_PARTITIONS);
    assign scan_limit = (piu_ext > max_ext) ? max_ext : piu_ext;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpa_pkg::POLICY_RESET;
            r_piu    <= fpa_pkg::PIU_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpa_pkg::CFG_FIT_POLICY:   r_policy <= i_cfg_data[fpa_pkg::POLICY_W-1:0];
                fpa_pkg::CFG_PARTS_IN_USE: r_piu    <= i_cfg_data[fpa_pkg::PIU_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_limit       = r_limit;
        n_cmp_vld     = r_cmp_vld;
        n_cmp_idx     = r_cmp_idx;
        n_size        = r_size;
        n_req_cnt     = r_req_cnt;
        n_out_valid   = r_out_valid;
        n_out_num     = r_out_num;
        n_out_granted = r_out_granted;
        n_out_chosen  = r_out_chosen;
        n_out_orig    = r_out_orig;

        if (rsp_xfer) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (is_request) begin
                    n_state   = S_SCAN;
                    n_idx     = '0;
                    n_limit   = scan_limit;
                    n_cmp_vld = 1'b0;
                    n_size    = in_size;
                end else if (is_load) begin
                    n_req_cnt = '0;
                end
            end
            S_SCAN: begin
                // Issue one table read per cycle; its compare follows in the next cycle.
                if (r_idx < r_limit) begin
                    n_idx     = r_idx + LIM_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if ((r_idx == r_limit) && !r_cmp_vld) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_num     = r_req_cnt;
                    n_out_granted = cmp_found;
                    n_out_chosen  = cmp_found ? fpa_pkg::CHOSEN_W'(cmp_pick) : '0;
                    n_out_orig    = cmp_found ? fpa_pkg::ORIG_W'(lds_rdata) : '0;
                    n_req_cnt     = r_req_cnt + fpa_pkg::REQ_NUM_W'(1);
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer state and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_limit     <= '0;
            r_cmp_vld   <= 1'b0;
            r_req_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_limit     <= n_limit;
            r_cmp_vld   <= n_cmp_vld;
            r_req_cnt   <= n_req_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmp_idx     <= n_cmp_idx;
        r_size        <= n_size;
        r_out_num     <= n_out_num;
        r_out_granted <= n_out_granted;
        r_out_chosen  <= n_out_chosen;
        r_out_orig    <= n_out_orig;
    end

    // Compare unit control.
    assign cmp_ctrl.clear = is_request;
    assign cmp_ctrl.valid = (r_state == S_SCAN) && r_cmp_vld;

    fpa_fit_cmp #(
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS)
    ) u_fit_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (cmp_ctrl),
        .i_policy (r_policy),
        .i_size   (r_size),
        .i_idx    (r_cmp_idx),
        .i_data   (rem_rdata),
        .o_found  (cmp_found),
        .o_pick   (cmp_pick),
        .o_best   (cmp_best)
    );

    // Remaining size table: written by loads and by the update after a grant.
    assign rem_we    = (is_load && slot_ok) || ((r_state == S_UPDATE) && cmp_found);
    assign rem_waddr = (r_state == S_UPDATE) ? cmp_pick : IDX_W'(i_req.partition_slot);
    assign rem_wdata = (r_state == S_UPDATE) ? (cmp_best - r_size) : in_size;

    fpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_remaining_ram (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (rem_waddr),
        .i_wdata (rem_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rem_rdata)
    );

    // Loaded size table: written by loads, read at the current pick.
    assign lds_we = is_load && slot_ok;

    fpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_loaded_ram (
        .i_clk   (i_clk),
        .i_we    (lds_we),
        .i_waddr (IDX_W'(i_req.partition_slot)),
        .i_wdata (in_size),
        .i_raddr (cmp_pick),
        .o_rdata (lds_rdata)
    );

    // Result channel.
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.request_number   = r_out_num;
    assign o_rsp.granted          = r_out_granted;
    assign o_rsp.chosen_partition = r_out_chosen;
    assign o_rsp.original_size    = r_out_orig;

    // The scan index never runs past the latched scan limit.
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_limit))
        else $error("scan index beyond scan limit");

    // A granted pick lies inside the scanned range.
    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && cmp_found) |-> (LIM_W'(cmp_pick) < r_limit))
        else $error("picked partition outside scanned range");

    // A request transfer starts a fresh scan at index zero.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_request |=> ((r_state == S_SCAN) && (r_idx == '0) && !cmp_found))
        else $error("request did not start a clean scan");

    // A finished result is held back while the output register is occupied.
    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && r_out_valid && !o_rsp.ready) |=> (r_state == S_FINISH))
        else $error("result overwrote a pending output");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit partition allocator testbench
// Loads the partition table and sends allocation requests under every fit
// policy and a range of scan counts. A predictor inside the bench tracks remaining sizes
// and the request counter. Each result is checked field by field against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int NPART         = fpa_pkg::MAX_PARTITIONS_DEF;
    localparam int SETTLE_CYCLES = 25;

    // One predicted allocation result.
    typedef struct packed {
        logic [fpa_pkg::REQ_NUM_W-1:0] number;
        logic                          granted;
        logic [fpa_pkg::CHOSEN_W-1:0]  slot;
        logic [fpa_pkg::ORIG_W-1:0]    orig_size;
    } t_grant;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data;

    fpa_req_if alloc_req ();
    fpa_rsp_if alloc_rsp ();

    fit_partition_allocator_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (alloc_req.sink),
        .o_rsp      (alloc_rsp.source)
    );

    // Predicted state of the allocator.
    logic [fpa_pkg::SIZE_W-1:0]    part_left [NPART];
    logic [fpa_pkg::SIZE_W-1:0]    part_size [NPART];
    logic [fpa_pkg::REQ_NUM_W-1:0] req_count;
    logic [fpa_pkg::POLICY_W-1:0]  fit_mode;
    logic [fpa_pkg::PIU_W-1:0]     scan_count;

    t_grant grants_due [$];
    t_grant head_grant;

    int  fail_count = 0;
    int  burst_left = 0;
    bit  gaps_on    = 1'b1;
    bit  stall_on   = 1'b1;
    int  ready_hold = 0;

    always #6 i_clk = ~i_clk;

    // Give up after a generous fixed time.
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    // Record and report one failure.
    task automatic note_failure(input string what, input int exp_val, input int got_val);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
    endtask

    // Work out the result of one request and update the predicted table.
    task automatic predict_allocation(input logic [fpa_pkg::SIZE_W-1:0] want);
        int     limit;
        int     pick;
        bit     found;
        t_grant r;
        limit = (scan_count > NPART) ? NPART : int'(scan_count);
        pick  = 0;
        found = 1'b0;
        for (int k = 0; k < limit; k++) begin
            if (part_left[k] >= want) begin
                case (fit_mode)
                    fpa_pkg::POLICY_BEST: begin
                        if (!found || part_left[k] < part_left[pick]) begin
                            pick  = k;
                            found = 1'b1;
                        end
                    end
                    fpa_pkg::POLICY_WORST: begin
                        if (!found || part_left[k] >= part_left[pick]) begin
                            pick  = k;
                            found = 1'b1;
                        end
                    end
                    default: begin
                        // First fit, and the unused code behaves the same.
                        if (!found) begin
                            pick  = k;
                            found = 1'b1;
                        end
                    end
                endcase
            end
        end
        r.number    = req_count;
        r.granted   = found;
        r.slot      = found ? fpa_pkg::CHOSEN_W'(pick) : '0;
        r.orig_size = found ? part_size[pick] : '0;
        if (found)
            part_left[pick] = part_left[pick] - want;
        req_count = req_count + fpa_pkg::REQ_NUM_W'(1);
        grants_due.push_back(r);
    endtask

    // Send one item, with a random gap between bursts, and predict it on transfer.
    task automatic send_item(input logic [fpa_pkg::OPCODE_W-1:0] op,
                             input logic [fpa_pkg::SLOT_W-1:0] slot,
                             input logic [fpa_pkg::SIZE_W-1:0] size);
        if (gaps_on && burst_left == 0) begin
            alloc_req.valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 4)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        alloc_req.valid          <= 1'b1;
        alloc_req.opcode         <= op;
        alloc_req.partition_slot <= slot;
        alloc_req.size_value     <= size;
        @(posedge i_clk);
        while (alloc_req.ready !== 1'b1) @(posedge i_clk);
        if (op == fpa_pkg::OP_LOAD) begin
            part_left[slot] = size;
            part_size[slot] = size;
            req_count       = '0;
        end else begin
            predict_allocation(size);
        end
        if (burst_left != 0) burst_left--;
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        alloc_req.valid <= 1'b0;
        burst_left = 0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one configuration register; only called while the block is idle.
    task automatic write_reg(input logic [fpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fpa_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == fpa_pkg::CFG_FIT_POLICY)
            fit_mode = data[fpa_pkg::POLICY_W-1:0];
        else
            scan_count = data[fpa_pkg::PIU_W-1:0];
        @(posedge i_clk);
    endtask

    // Result side: stall on its own pattern of ready runs and stalls.
    initial alloc_rsp.ready = 1'b0;
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!stall_on || !alloc_rsp.ready) begin
            alloc_rsp.ready <= 1'b1;
            ready_hold      <= $urandom_range(0, 9);
        end else begin
            alloc_rsp.ready <= 1'b0;
            ready_hold      <= $urandom_range(0, 5);
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && alloc_rsp.valid === 1'b1 && alloc_rsp.ready === 1'b1) begin
            if (grants_due.size() == 0) begin
                note_failure("unexpected result, request_number", -1,
                             int'(alloc_rsp.request_number));
            end else begin
                head_grant = grants_due.pop_front();
                if (alloc_rsp.request_number !== head_grant.number)
                    note_failure("request_number", int'(head_grant.number),
                                 int'(alloc_rsp.request_number));
                if (alloc_rsp.granted !== head_grant.granted)
                    note_failure("granted", int'(head_grant.granted),
                                 int'(alloc_rsp.granted));
                if (alloc_rsp.chosen_partition !== head_grant.slot)
                    note_failure("chosen_partition", int'(head_grant.slot),
                                 int'(alloc_rsp.chosen_partition));
                if (alloc_rsp.original_size !== head_grant.orig_size)
                    note_failure("original_size", int'(head_grant.orig_size),
                                 int'(alloc_rsp.original_size));
            end
        end
    end

    // Fill the whole table, then allocate under the reset configuration.
    task automatic test_reset_defaults();
        logic [fpa_pkg::SIZE_W-1:0] fill;
        for (int k = 0; k < NPART; k++) begin
            case (k)
                0:       fill = '0;
                1:       fill = '1;
                2, 4:    fill = 16'd300;
                3, 5:    fill = 16'd40;
                6, 7:    fill = 16'd1000;
                default: fill = fpa_pkg::SIZE_W'(k * 10);
            endcase
            send_item(fpa_pkg::OP_LOAD, fpa_pkg::SLOT_W'(k), fill);
        end
        send_item(fpa_pkg::OP_REQUEST, '0, 16'd0);
        send_item(fpa_pkg::OP_REQUEST, '0, 16'hFFFF);
        send_item(fpa_pkg::OP_REQUEST, '0, 16'hFFFF);
        send_item(fpa_pkg::OP_REQUEST, '0, 16'd35);
    endtask

    // Ties and ordering under best fit, worst fit and the unused policy code.
    task automatic test_fit_policies();
        logic [fpa_pkg::CFG_DATA_W-1:0] mode_words [3];
        mode_words[0] = fpa_pkg::CFG_DATA_W'(fpa_pkg::POLICY_BEST);
        mode_words[1] = fpa_pkg::CFG_DATA_W'(fpa_pkg::POLICY_WORST);
        mode_words[2] = '1;    // upper bits set, low bits give the unused code
        foreach (mode_words[m]) begin
            drain_results();
            write_reg(fpa_pkg::CFG_FIT_POLICY, mode_words[m]);
            send_item(fpa_pkg::OP_LOAD, fpa_pkg::SLOT_W'(3), 16'd40);
            send_item(fpa_pkg::OP_REQUEST, '0, 16'd40);
            send_item(fpa_pkg::OP_REQUEST, '0, 16'd300);
            send_item(fpa_pkg::OP_REQUEST, '0, 16'd60);
        end
    endtask

    // Scan counts of zero, the minimum, values that saturate and the maximum.
    task automatic test_scan_count();
        logic [fpa_pkg::PIU_W-1:0] counts [5];
        counts = '{5'd0, 5'd31, 5'd17, 5'd1, 5'd16};
        foreach (counts[c]) begin
            drain_results();
            write_reg(fpa_pkg::CFG_PARTS_IN_USE, fpa_pkg::CFG_DATA_W'(counts[c]));
            send_item(fpa_pkg::OP_REQUEST, '0, 16'd0);
            send_item(fpa_pkg::OP_REQUEST, '0, 16'd70);
        end
    endtask

    // Random phases: mostly requests, many sized near what is left, some reloads.
    task automatic test_random_traffic();
        logic [fpa_pkg::SIZE_W-1:0] size;
        logic [fpa_pkg::PIU_W-1:0]  piu;
        for (int phase = 0; phase < 9; phase++) begin
            drain_results();
            write_reg(fpa_pkg::CFG_FIT_POLICY, fpa_pkg::CFG_DATA_W'($urandom_range(0, 31)));
            case ($urandom_range(0, 5))
                0:       piu = 5'd0;
                1:       piu = 5'd1;
                2:       piu = 5'd16;
                3:       piu = 5'd31;
                default: piu = fpa_pkg::PIU_W'($urandom_range(0, 31));
            endcase
            write_reg(fpa_pkg::CFG_PARTS_IN_USE, fpa_pkg::CFG_DATA_W'(piu));
            gaps_on  = (phase % 3 != 2);
            stall_on = (phase % 4 != 3);
            for (int n = 0; n < 55; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 5))
                        0:       size = '0;
                        1:       size = '1;
                        default: size = fpa_pkg::SIZE_W'($urandom);
                    endcase
                    send_item(fpa_pkg::OP_LOAD,
                              fpa_pkg::SLOT_W'($urandom_range(0, NPART - 1)), size);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       size = fpa_pkg::SIZE_W'($urandom_range(0, 3));
                        1:       size = fpa_pkg::SIZE_W'($urandom);
                        default: size = part_left[$urandom_range(0, NPART - 1)] -
                                        fpa_pkg::SIZE_W'($urandom_range(0, 2));
                    endcase
                    send_item(fpa_pkg::OP_REQUEST, '0, size);
                end
                // Now and then hold off until every result is back.
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // Count a long run of back-to-back requests with one partition scanned.
    task automatic test_counter_run();
        drain_results();
        write_reg(fpa_pkg::CFG_FIT_POLICY, fpa_pkg::CFG_DATA_W'(fpa_pkg::POLICY_FIRST));
        write_reg(fpa_pkg::CFG_PARTS_IN_USE, 5'd1);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        send_item(fpa_pkg::OP_LOAD, '0, '1);
        for (int n = 0; n < 30; n++)
            send_item(fpa_pkg::OP_REQUEST, '0, fpa_pkg::SIZE_W'($urandom_range(0, 1)));
        drain_results();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // Reset once, then run each test in turn.
    initial begin
        i_rst_n                  = 1'b0;
        cfg_we                   = 1'b0;
        cfg_idx                  = fpa_pkg::CFG_FIT_POLICY;
        cfg_data                 = '0;
        alloc_req.valid          = 1'b0;
        alloc_req.opcode         = fpa_pkg::OP_LOAD;
        alloc_req.partition_slot = '0;
        alloc_req.size_value     = '0;
        for (int k = 0; k < NPART; k++) begin
            part_left[k] = '0;
            part_size[k] = '0;
        end
        req_count  = '0;
        fit_mode   = fpa_pkg::POLICY_RESET;
        scan_count = fpa_pkg::PIU_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_fit_policies();
        test_scan_count();
        test_random_traffic();
        test_counter_run();
        drain_results();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/fpa_pkg.sv
sv/fpa_req_if.sv
sv/fpa_rsp_if.sv
sv/fpa_ram.sv
sv/fpa_fit_cmp.sv
sv/fit_partition_allocator_unit.sv
sim/tb.sv
